// ===== rtl/core/csstok_pkg.sv =====
// Shared types, codes and byte constants of the stylesheet tokenizer.
package csstok_pkg;

	localparam int LINE_BITS_DEF = 32;
	localparam int QUEUE_DEPTH   = 4;
	localparam int MAX_EVENTS    = 3;

	// event kinds
	localparam logic [3:0] EV_TOKEN     = 4'd0;
	localparam logic [3:0] EV_TAG_END   = 4'd1;
	localparam logic [3:0] EV_ID_END    = 4'd2;
	localparam logic [3:0] EV_CLASS_END = 4'd3;
	localparam logic [3:0] EV_SEL_END   = 4'd4;
	localparam logic [3:0] EV_CHAIN_END = 4'd5;
	localparam logic [3:0] EV_COMB      = 4'd6;
	localparam logic [3:0] EV_NAME_END  = 4'd7;
	localparam logic [3:0] EV_VALUE_END = 4'd8;
	localparam logic [3:0] EV_BLOCK_END = 4'd9;
	localparam logic [3:0] EV_ERROR     = 4'd10;

	// error codes
	localparam logic [2:0] ERR_ATTR       = 3'd0;
	localparam logic [2:0] ERR_HASH       = 3'd1;
	localparam logic [2:0] ERR_COMB_UNK   = 3'd2;
	localparam logic [2:0] ERR_COMB_UNEXP = 3'd3;
	localparam logic [2:0] ERR_AFTER_NAME = 3'd4;
	localparam logic [2:0] ERR_AFTER_VAL  = 3'd5;

	// characters
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_TILDE  = 8'h7E;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_LBRACK = 8'h5B;

	typedef enum logic [10:0] {
		ST_IDLE  = 11'b00000000001,
		ST_BLOCK = 11'b00000000010,
		ST_TAG   = 11'b00000000100,
		ST_ID    = 11'b00000001000,
		ST_CLASS = 11'b00000010000,
		ST_COMB  = 11'b00000100000,
		ST_NAME  = 11'b00001000000,
		ST_DELIM = 11'b00010000000,
		ST_VALUE = 11'b00100000000,
		ST_TERM  = 11'b01000000000,
		ST_ERR   = 11'b10000000000
	} parse_state_t;

	typedef struct packed {
		logic [3:0] kind;
		logic [7:0] ch;
		logic [2:0] code;
	} event_t;

	// all events caused by one byte, with the line number they share
	typedef struct packed {
		logic [1:0]   count;
		event_t [2:0] ev;
		logic [31:0]  line;
	} bundle_t;

	function automatic event_t mk_ev(logic [3:0] kind, logic [7:0] ch, logic [2:0] code);
		event_t e;
		e.kind = kind;
		e.ch   = ch;
		e.code = code;
		return e;
	endfunction

endpackage

// ===== rtl/core/csstok_front.sv =====
// Front end: parse state machine, line counter and event bundle builder.
module csstok_front import csstok_pkg::*; #(
	parameter int LINE_BITS = LINE_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  logic [7:0] byte_in,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic      first_line_number,
	input  logic      q_full,
	output logic      q_push,
	output bundle_t   q_data
);

	parse_state_t           state_q, state_d;
	logic                   tok_q, tok_d;
	logic [7:0]             cc_q, cc_d;
	logic                   held_q, held_d;
	logic [LINE_BITS-1:0]   line_q, line_d;
	logic [LINE_BITS+31:0]  line_ext;
	logic                   accept;
	logic                   ws;
	logic [3:0]             sel_kind;
	bundle_t                bnd;

	assign full      = q_full;
	assign cfg_ready = 1'b1;
	assign accept    = push && !q_full;
	assign ws = (byte_in == CH_SPACE) || (byte_in == CH_CR) || (byte_in == CH_TAB) ||
		(byte_in == CH_LF);

	always_comb begin
		line_d = line_q;
		if (byte_in == CH_LF && line_q != {LINE_BITS{1'b1}}) begin
			line_d = line_q + {{(LINE_BITS-1){1'b0}}, 1'b1};
		end
	end

	// clamp the reported line to 32 bits
	assign line_ext = {32'd0, line_d};

	always_comb begin
		unique case (state_q)
			ST_ID:    sel_kind = EV_ID_END;
			ST_CLASS: sel_kind = EV_CLASS_END;
			default:  sel_kind = EV_TAG_END;
		endcase
	end

	always_comb begin
		state_d = state_q;
		tok_d   = tok_q;
		cc_d    = cc_q;
		held_d  = held_q;
		bnd.count = 2'd0;
		bnd.ev    = '0;
		bnd.line  = (line_ext[LINE_BITS+31:32] != '0) ? 32'hFFFFFFFF : line_ext[31:0];
		unique case (state_q)
			ST_IDLE: begin
				if (!ws) begin
					priority if (byte_in == CH_DOT) begin
						state_d = ST_CLASS;
					end else if (byte_in == CH_HASH) begin
						state_d = ST_ID;
					end else if (byte_in == CH_LBRACK) begin
						bnd.ev[0] = mk_ev(EV_ERROR, CH_NUL, ERR_ATTR);
						bnd.count = 2'd1;
						state_d = ST_ERR;
					end else begin
						bnd.ev[0] = mk_ev(EV_TOKEN, byte_in, 3'd0);
						bnd.count = 2'd1;
						tok_d = 1'b1;
						state_d = ST_TAG;
					end
				end
			end
			ST_BLOCK: begin
				if (!ws) begin
					if (byte_in == CH_RBRACE) begin
						bnd.ev[0] = mk_ev(EV_BLOCK_END, CH_NUL, 3'd0);
						bnd.count = 2'd1;
						state_d = ST_IDLE;
					end else begin
						bnd.ev[0] = mk_ev(EV_TOKEN, byte_in, 3'd0);
						bnd.count = 2'd1;
						tok_d = 1'b1;
						state_d = ST_NAME;
					end
				end
			end
			ST_TAG, ST_ID, ST_CLASS: begin
				priority if (ws) begin
					bnd.ev[0] = mk_ev(sel_kind, CH_NUL, 3'd0);
					bnd.ev[1] = mk_ev(EV_SEL_END, CH_NUL, 3'd0);
					bnd.count = 2'd2;
					tok_d = 1'b0;
					state_d = ST_COMB;
				end else if (byte_in == CH_LBRACE || byte_in == CH_COMMA) begin
					bnd.ev[0] = mk_ev(sel_kind, CH_NUL, 3'd0);
					bnd.ev[1] = mk_ev(EV_SEL_END, CH_NUL, 3'd0);
					bnd.ev[2] = mk_ev(EV_CHAIN_END, CH_NUL, 3'd0);
					bnd.count = 2'd3;
					tok_d = 1'b0;
					state_d = (byte_in == CH_LBRACE) ? ST_BLOCK : ST_IDLE;
				end else if (byte_in == CH_LBRACK) begin
					bnd.ev[0] = mk_ev(EV_ERROR, CH_NUL, ERR_ATTR);
					bnd.count = 2'd1;
					state_d = ST_ERR;
				end else if (byte_in == CH_HASH && state_q == ST_ID) begin
					bnd.ev[0] = mk_ev(EV_ERROR, CH_NUL, ERR_HASH);
					bnd.count = 2'd1;
					state_d = ST_ERR;
				end else if (byte_in == CH_DOT || byte_in == CH_HASH) begin
					bnd.ev[0] = mk_ev(sel_kind, CH_NUL, 3'd0);
					bnd.count = 2'd1;
					tok_d = 1'b0;
					state_d = (byte_in == CH_DOT) ? ST_CLASS : ST_ID;
				end else begin
					bnd.ev[0] = mk_ev(EV_TOKEN, byte_in, 3'd0);
					bnd.count = 2'd1;
					tok_d = 1'b1;
				end
			end
			ST_COMB: begin
				priority if (ws) begin
					if (held_q) begin
						bnd.ev[0] = mk_ev(EV_COMB, cc_q, 3'd0);
						bnd.count = 2'd1;
						held_d = 1'b0;
						cc_d = CH_NUL;
						state_d = ST_IDLE;
					end
				end else if (byte_in == CH_GT || byte_in == CH_PLUS || byte_in == CH_TILDE) begin
					if (held_q) begin
						bnd.ev[0] = mk_ev(EV_ERROR, CH_NUL, ERR_COMB_UNK);
						bnd.count = 2'd1;
						state_d = ST_ERR;
					end else begin
						held_d = 1'b1;
						cc_d = byte_in;
					end
				end else if (byte_in == CH_LBRACE || byte_in == CH_COMMA) begin
					if (held_q) begin
						bnd.ev[0] = mk_ev(EV_ERROR, CH_NUL, ERR_COMB_UNEXP);
						bnd.count = 2'd1;
						state_d = ST_ERR;
					end else begin
						bnd.ev[0] = mk_ev(EV_CHAIN_END, CH_NUL, 3'd0);
						bnd.count = 2'd1;
						state_d = (byte_in == CH_LBRACE) ? ST_BLOCK : ST_IDLE;
					end
				end else begin
					// a pending combinator, or a plain descendant, goes out first
					bnd.ev[0] = mk_ev(EV_COMB, held_q ? cc_q : CH_NUL, 3'd0);
					bnd.count = 2'd1;
					held_d = 1'b0;
					cc_d = CH_NUL;
					priority if (byte_in == CH_DOT) begin
						state_d = ST_CLASS;
					end else if (byte_in == CH_LBRACK) begin
						bnd.ev[1] = mk_ev(EV_ERROR, CH_NUL, ERR_ATTR);
						bnd.count = 2'd2;
						state_d = ST_ERR;
					end else begin
						bnd.ev[1] = mk_ev(EV_TOKEN, byte_in, 3'd0);
						bnd.count = 2'd2;
						tok_d = 1'b1;
						state_d = ST_TAG;
					end
				end
			end
			ST_NAME, ST_VALUE: begin
				priority if (ws) begin
					if (tok_q) begin
						bnd.ev[0] = mk_ev((state_q == ST_NAME) ? EV_NAME_END : EV_VALUE_END,
							CH_NUL, 3'd0);
						bnd.count = 2'd1;
						tok_d = 1'b0;
						state_d = (state_q == ST_NAME) ? ST_DELIM : ST_TERM;
					end
				end else if ((state_q == ST_NAME && byte_in == CH_COLON) ||
						(state_q == ST_VALUE && byte_in == CH_SEMI)) begin
					bnd.ev[0] = mk_ev((state_q == ST_NAME) ? EV_NAME_END : EV_VALUE_END,
						CH_NUL, 3'd0);
					bnd.count = 2'd1;
					tok_d = 1'b0;
					state_d = (state_q == ST_NAME) ? ST_VALUE : ST_BLOCK;
				end else begin
					bnd.ev[0] = mk_ev(EV_TOKEN, byte_in, 3'd0);
					bnd.count = 2'd1;
					tok_d = 1'b1;
				end
			end
			ST_DELIM: begin
				if (!ws) begin
					if (byte_in == CH_COLON) begin
						state_d = ST_VALUE;
					end else begin
						bnd.ev[0] = mk_ev(EV_ERROR, CH_NUL, ERR_AFTER_NAME);
						bnd.count = 2'd1;
						state_d = ST_ERR;
					end
				end
			end
			ST_TERM: begin
				if (!ws) begin
					priority if (byte_in == CH_SEMI) begin
						state_d = ST_BLOCK;
					end else if (byte_in == CH_RBRACE) begin
						bnd.ev[0] = mk_ev(EV_BLOCK_END, CH_NUL, 3'd0);
						bnd.count = 2'd1;
						state_d = ST_IDLE;
					end else begin
						bnd.ev[0] = mk_ev(EV_ERROR, CH_NUL, ERR_AFTER_VAL);
						bnd.count = 2'd1;
						state_d = ST_ERR;
					end
				end
			end
			default: begin
				// sticky error: hold everything
			end
		endcase
	end

	assign q_data = bnd;
	assign q_push = accept && (bnd.count != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			tok_q   <= 1'b0;
			cc_q    <= CH_NUL;
			held_q  <= 1'b0;
			line_q  <= {{(LINE_BITS-1){1'b0}}, 1'b1};
		end else if (cfg_valid) begin
			line_q <= {{(LINE_BITS-1){1'b0}}, first_line_number};
		end else if (accept && state_q != ST_ERR) begin
			state_q <= state_d;
			tok_q   <= tok_d;
			cc_q    <= cc_d;
			held_q  <= held_d;
			if (state_q == ST_IDLE || state_q == ST_BLOCK || state_q == ST_TAG ||
					state_q == ST_ID || state_q == ST_CLASS || state_q == ST_COMB ||
					state_q == ST_NAME || state_q == ST_DELIM || state_q == ST_VALUE ||
					state_q == ST_TERM) begin
				line_q <= line_d;
			end
		end
	end

endmodule

// ===== rtl/core/csstok_queue.sv =====
// Short bundle queue between the parser and the event serializer.
module csstok_queue import csstok_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  bundle_t wdata,
	output logic    full,
	input  logic    pop,
	output bundle_t rdata,
	output logic    empty
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	bundle_t         mem_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_q, rd_q;
	logic [CW-1:0]   count_q;
	logic            do_push, do_pop;

	assign full    = (count_q == CW'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (count_q == $past(count_q) + CW'(1)))
		else $error("push without pop did not grow the queue");

endmodule

// ===== rtl/core/csstok_back.sv =====
// Back end: walks the events of the head bundle out one per pop.
module csstok_back import csstok_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  bundle_t     head,
	input  logic        q_empty,
	output logic        q_pop,
	input  logic        pop,
	output logic        empty,
	output logic [3:0]  event_kind,
	output logic [7:0]  char_value,
	output logic [2:0]  error_code,
	output logic [31:0] line_number,
	output logic        last_of_run
);

	logic [1:0] idx_q;
	event_t     cur;
	logic       take;

	assign empty       = q_empty;
	assign cur         = head.ev[idx_q];
	assign event_kind  = cur.kind;
	assign char_value  = cur.ch;
	assign error_code  = cur.code;
	assign line_number = head.line;
	assign last_of_run = (idx_q == head.count - 2'd1);
	assign take        = pop && !q_empty;
	assign q_pop       = take && last_of_run;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
		end else if (take) begin
			// advance within the bundle, rewind when it is done
			idx_q <= last_of_run ? 2'd0 : idx_q + 2'd1;
		end
	end

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		!q_empty |-> (head.count != 2'd0))
		else $error("empty bundle in queue");

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		!q_empty |-> (idx_q < head.count))
		else $error("event index past bundle end");

	a_idle_rewound: assert property (@(posedge clk) disable iff (!arst_n)
		q_empty |-> (idx_q == 2'd0))
		else $error("event index not rewound while queue empty");

endmodule

// ===== rtl/core/css_selector_rule_tokenizer_core.sv =====
// Top level of the stylesheet selector and rule tokenizer.
//
// Input side is a queue write port: drive byte_in with push high; the byte is
// taken at a clock edge where full is low; one byte can go in every such cycle.
// Result side is a queue read port: while empty is low the oldest event sits on
// event_kind, char_value, error_code, line_number and last_of_run; pop high at
// an edge takes it. last_of_run marks the final event of one byte.
// Once taken, a byte's events are queued behind older ones. Bytes causing no
// event (most whitespace, every byte in the error state) leave no trace on the
// result side. Events drain at one per cycle while pop is high, so a byte
// causing k events takes k pops; the four-entry bundle queue between parser
// and serializer absorbs these bursts, and full rises only once it fills.
// When the receiver stalls, the queue fills and full holds the sender off.
// The configuration channel (cfg_valid, cfg_ready, first_line_number) is always
// ready and loads the line counter; write it only while the block is idle.
// Reset empties the queue, returns the parser to idle and sets the line to 1.
module css_selector_rule_tokenizer_core import csstok_pkg::*; #(
	parameter int LINE_BITS = LINE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  byte_in,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        first_line_number,
	output logic        empty,
	input  logic        pop,
	output logic [3:0]  event_kind,
	output logic [7:0]  char_value,
	output logic [2:0]  error_code,
	output logic [31:0] line_number,
	output logic        last_of_run
);

	bundle_t q_wdata, q_rdata;
	logic    q_push, q_full, q_pop, q_empty;

	csstok_front #(.LINE_BITS(LINE_BITS)) u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.push              (push),
		.full              (full),
		.byte_in           (byte_in),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.first_line_number (first_line_number),
		.q_full            (q_full),
		.q_push            (q_push),
		.q_data            (q_wdata)
	);

	csstok_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	csstok_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (q_rdata),
		.q_empty     (q_empty),
		.q_pop       (q_pop),
		.pop         (pop),
		.empty       (empty),
		.event_kind  (event_kind),
		.char_value  (char_value),
		.error_code  (error_code),
		.line_number (line_number),
		.last_of_run (last_of_run)
	);

endmodule

// ===== tb/tb_css_selector_rule_tokenizer_core.sv =====
// Self-checking testbench for the stylesheet selector and rule tokenizer core.
module tb_css_selector_rule_tokenizer_core;
	import csstok_pkg::*;

	localparam bit [2:0] NO_CODE      = 3'd0;
	localparam int       DRAIN_CYCLES = 8;
	localparam int       QUIET_LIMIT  = 1000;
	localparam int       HOLD_AT      = 50;
	localparam int       HOLD_CYCLES  = 120;
	localparam int       PHASE_BYTES  = 100;

	typedef struct {
		bit [3:0]  kind;
		bit [7:0]  ch;
		bit [2:0]  code;
		bit [31:0] line;
		bit        last;
	} tok_event_t;

	typedef enum int {
		FT_ATTR, FT_HASH, FT_COMB_TWICE, FT_COMB_BRACE, FT_AFTER_NAME, FT_AFTER_VALUE,
		FT_COMB_BRACKET
	} fault_tail_t;

	// Predicts the events of each byte and holds those still to come out of the block.
	class css_event_board;
		parse_state_t st;
		bit           tok_open;
		bit [7:0]     comb_ch;
		bit           comb_held;
		bit [31:0]    lines;
		tok_event_t   burst[$];
		tok_event_t   pending_events[$];
		int           mismatches;
		int           bytes_noted;
		int           events_checked;
		bit [15:0]    kinds_seen;

		function new();
			st = ST_IDLE;
			tok_open = 1'b0;
			comb_ch = CH_NUL;
			comb_held = 1'b0;
			lines = 32'd1;
			mismatches = 0;
			bytes_noted = 0;
			events_checked = 0;
			kinds_seen = '0;
		endfunction

		function void load_first_line(bit v);
			lines = {31'b0, v};
		endfunction

		function void add(bit [3:0] kind, bit [7:0] ch, bit [2:0] code);
			tok_event_t e;
			e.kind = kind;
			e.ch   = ch;
			e.code = code;
			e.line = lines;
			e.last = 1'b0;
			burst.insert(burst.size(), e);
		endfunction

		function void fail_with(bit [2:0] code);
			add(EV_ERROR, CH_NUL, code);
			st = ST_ERR;
		endfunction

		function void token(bit [7:0] b);
			add(EV_TOKEN, b, NO_CODE);
			tok_open = 1'b1;
		endfunction

		function void end_simple(bit [3:0] kind, parse_state_t nxt, bit chain);
			add(kind, CH_NUL, NO_CODE);
			add(EV_SEL_END, CH_NUL, NO_CODE);
			if (chain)
				add(EV_CHAIN_END, CH_NUL, NO_CODE);
			tok_open = 1'b0;
			st = nxt;
		endfunction

		function void selector_byte(bit [7:0] b, bit ws, bit [3:0] kind);
			if (ws) begin
				end_simple(kind, ST_COMB, 1'b0);
				return;
			end
			case (b)
				CH_LBRACE: end_simple(kind, ST_BLOCK, 1'b1);
				CH_COMMA:  end_simple(kind, ST_IDLE, 1'b1);
				CH_LBRACK: fail_with(ERR_ATTR);
				CH_DOT: begin
					add(kind, CH_NUL, NO_CODE);
					tok_open = 1'b0;
					st = ST_CLASS;
				end
				CH_HASH: begin
					// a second hash inside an id is stray; after a tag or class it opens an id
					if (kind == EV_ID_END) begin
						fail_with(ERR_HASH);
					end else begin
						add(kind, CH_NUL, NO_CODE);
						tok_open = 1'b0;
						st = ST_ID;
					end
				end
				default: token(b);
			endcase
		endfunction

		function void combinator_byte(bit [7:0] b, bit ws);
			if (ws) begin
				if (comb_held) begin
					add(EV_COMB, comb_ch, NO_CODE);
					comb_held = 1'b0;
					comb_ch = CH_NUL;
					st = ST_IDLE;
				end
				return;
			end
			case (b)
				CH_GT, CH_PLUS, CH_TILDE: begin
					if (comb_held) begin
						fail_with(ERR_COMB_UNK);
					end else begin
						comb_held = 1'b1;
						comb_ch = b;
					end
				end
				CH_LBRACE, CH_COMMA: begin
					if (comb_held) begin
						fail_with(ERR_COMB_UNEXP);
					end else begin
						add(EV_CHAIN_END, CH_NUL, NO_CODE);
						st = (b == CH_LBRACE) ? ST_BLOCK : ST_IDLE;
					end
				end
				default: begin
					// the next compound begins: flush the combinator, plain descendant if none held
					add(EV_COMB, comb_held ? comb_ch : CH_NUL, NO_CODE);
					comb_held = 1'b0;
					comb_ch = CH_NUL;
					if (b == CH_DOT) begin
						st = ST_CLASS;
					end else if (b == CH_LBRACK) begin
						fail_with(ERR_ATTR);
					end else begin
						token(b);
						st = ST_TAG;
					end
				end
			endcase
		endfunction

		function void field_byte(bit [7:0] b, bit ws);
			bit       is_name;
			bit [3:0] end_kind;
			is_name = (st == ST_NAME);
			end_kind = is_name ? EV_NAME_END : EV_VALUE_END;
			if (ws) begin
				if (tok_open) begin
					add(end_kind, CH_NUL, NO_CODE);
					tok_open = 1'b0;
					st = is_name ? ST_DELIM : ST_TERM;
				end
			end else if (b == (is_name ? CH_COLON : CH_SEMI)) begin
				add(end_kind, CH_NUL, NO_CODE);
				tok_open = 1'b0;
				st = is_name ? ST_VALUE : ST_BLOCK;
			end else begin
				token(b);
			end
		endfunction

		function void tokenize_byte(bit [7:0] b);
			bit ws;
			burst.delete();
			ws = (b == CH_SPACE || b == CH_CR || b == CH_TAB || b == CH_LF);
			if (st == ST_ERR)
				return;
			if (b == CH_LF && lines != '1)
				lines++;
			case (st)
				ST_IDLE: begin
					if (!ws) begin
						if (b == CH_DOT) begin
							st = ST_CLASS;
						end else if (b == CH_HASH) begin
							st = ST_ID;
						end else if (b == CH_LBRACK) begin
							fail_with(ERR_ATTR);
						end else begin
							token(b);
							st = ST_TAG;
						end
					end
				end
				ST_BLOCK: begin
					if (!ws) begin
						if (b == CH_RBRACE) begin
							add(EV_BLOCK_END, CH_NUL, NO_CODE);
							st = ST_IDLE;
						end else begin
							token(b);
							st = ST_NAME;
						end
					end
				end
				ST_TAG:   selector_byte(b, ws, EV_TAG_END);
				ST_ID:    selector_byte(b, ws, EV_ID_END);
				ST_CLASS: selector_byte(b, ws, EV_CLASS_END);
				ST_COMB:  combinator_byte(b, ws);
				ST_NAME, ST_VALUE: field_byte(b, ws);
				ST_DELIM: begin
					if (!ws) begin
						if (b == CH_COLON)
							st = ST_VALUE;
						else
							fail_with(ERR_AFTER_NAME);
					end
				end
				ST_TERM: begin
					if (!ws) begin
						if (b == CH_SEMI) begin
							st = ST_BLOCK;
						end else if (b == CH_RBRACE) begin
							add(EV_BLOCK_END, CH_NUL, NO_CODE);
							st = ST_IDLE;
						end else begin
							fail_with(ERR_AFTER_VAL);
						end
					end
				end
				default: ;
			endcase
			if (burst.size() > 0)
				burst[burst.size() - 1].last = 1'b1;
		endfunction

		// dry run: does this byte drive the parse into the error state
		function bit would_fail(bit [7:0] b);
			parse_state_t s_st;
			bit           s_open;
			bit [7:0]     s_ch;
			bit           s_held;
			bit [31:0]    s_lines;
			s_st = st;
			s_open = tok_open;
			s_ch = comb_ch;
			s_held = comb_held;
			s_lines = lines;
			tokenize_byte(b);
			would_fail = (st == ST_ERR) && (s_st != ST_ERR);
			st = s_st;
			tok_open = s_open;
			comb_ch = s_ch;
			comb_held = s_held;
			lines = s_lines;
			burst.delete();
		endfunction

		function void note_byte(bit [7:0] b);
			tokenize_byte(b);
			bytes_noted++;
			foreach (burst[i])
				pending_events.insert(pending_events.size(), burst[i]);
		endfunction

		function void check_event(bit [3:0] kind, bit [7:0] ch, bit [2:0] code,
				bit [31:0] line, bit last);
			tok_event_t e;
			events_checked++;
			kinds_seen[kind] = 1'b1;
			if (pending_events.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected event: kind %0d ch %02h code %0d line %0d last %0b",
						kind, ch, code, line, last);
				mismatches++;
				return;
			end
			e = pending_events.pop_front();
			if (e.kind != kind || e.ch != ch || e.code != code || e.line != line ||
					e.last != last) begin
				if (mismatches < 10) begin
					$display("event mismatch: expected kind %0d ch %02h code %0d line %0d last %0b",
						e.kind, e.ch, e.code, e.line, e.last);
					$display("                got      kind %0d ch %02h code %0d line %0d last %0b",
						kind, ch, code, line, last);
				end
				mismatches++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [7:0]  byte_in = 8'h00;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        first_line_number = 1'b1;
	logic        empty;
	logic        pop = 1'b0;
	logic [3:0]  event_kind;
	logic [7:0]  char_value;
	logic [2:0]  error_code;
	logic [31:0] line_number;
	logic        last_of_run;

	css_event_board sb = new();
	css_event_board shaper = new();

	bit [7:0]    text_q[$];
	bit          tx_steady = 1'b0;
	bit          rx_steady = 1'b0;
	bit          noisy = 1'b0;
	int          popped = 0;
	int          quiet_cycles = 0;
	fault_tail_t tail_used;

	css_selector_rule_tokenizer_core u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.byte_in          (byte_in),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.first_line_number(first_line_number),
		.empty            (empty),
		.pop              (pop),
		.event_kind       (event_kind),
		.char_value       (char_value),
		.error_code       (error_code),
		.line_number      (line_number),
		.last_of_run      (last_of_run)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ---------------- text shaping ----------------

	function automatic int draw_gap(inout bit steady);
		if ($urandom_range(0, 15) == 0)
			steady = ~steady;
		return steady ? 0 : $urandom_range(0, 7);
	endfunction

	function automatic bit is_special(bit [7:0] b);
		case (b)
			CH_LF, CH_CR, CH_TAB, CH_SPACE, CH_GT, CH_PLUS, CH_TILDE, CH_COLON, CH_SEMI,
			CH_LBRACE, CH_RBRACE, CH_COMMA, CH_HASH, CH_DOT, CH_LBRACK: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic bit [7:0] plain_byte();
		bit [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (is_special(b));
		return b;
	endfunction

	function automatic bit [7:0] ws_byte();
		case ($urandom_range(0, 3))
			0: return CH_TAB;
			1: return CH_CR;
			2: return CH_LF;
			default: return CH_SPACE;
		endcase
	endfunction

	function automatic void put_raw(bit [7:0] b);
		shaper.tokenize_byte(b);
		text_q.insert(text_q.size(), b);
	endfunction

	// keep the run alive: a byte that would end it in the error state becomes a space
	function automatic void put(bit [7:0] b);
		if (shaper.would_fail(b))
			b = CH_SPACE;
		put_raw(b);
	endfunction

	function automatic void put_sym(bit [7:0] b);
		if (noisy && $urandom_range(0, 11) == 0)
			put(8'($urandom_range(0, 255)));
		put(b);
	endfunction

	function automatic void put_str(string s);
		for (int i = 0; i < s.len(); i++)
			put(s[i]);
	endfunction

	function automatic void put_word(int lo, int hi);
		int n;
		n = $urandom_range(lo, hi);
		repeat (n) put_sym(plain_byte());
	endfunction

	function automatic void gen_compound();
		bit has_tag;
		int nsub;
		bit prev_id;
		has_tag = 1'($urandom_range(0, 1));
		nsub = has_tag ? $urandom_range(0, 2) : $urandom_range(1, 2);
		prev_id = 1'b0;
		if (has_tag)
			put_word(1, 3);
		for (int j = 0; j < nsub; j++) begin
			if (!prev_id && $urandom_range(0, 1)) begin
				put_sym(CH_HASH);
				prev_id = 1'b1;
			end else begin
				put_sym(CH_DOT);
				prev_id = 1'b0;
			end
			put_word(1, 3);
		end
	endfunction

	function automatic void gen_rule();
		int n_sel;
		int n_cmp;
		int n_prop;
		int k;
		n_sel = $urandom_range(1, 3);
		for (int s = 0; s < n_sel; s++) begin
			if (s > 0) begin
				case ($urandom_range(0, 2))
					0: put_sym(CH_COMMA);
					1: begin
						put_sym(ws_byte());
						put_sym(CH_COMMA);
					end
					default: begin
						put_sym(CH_COMMA);
						put_sym(ws_byte());
					end
				endcase
			end
			n_cmp = $urandom_range(1, 3);
			for (int c = 0; c < n_cmp; c++) begin
				if (c > 0) begin
					put_sym(ws_byte());
					k = $urandom_range(0, 3);
					if (k > 0) begin
						put_sym(k == 1 ? CH_GT : (k == 2 ? CH_PLUS : CH_TILDE));
						if ($urandom_range(0, 1))
							put_sym(ws_byte());
					end
				end
				gen_compound();
			end
		end
		if ($urandom_range(0, 1))
			put_sym(ws_byte());
		put_sym(CH_LBRACE);
		n_prop = $urandom_range(0, 3);
		for (int p = 0; p < n_prop; p++) begin
			if ($urandom_range(0, 1))
				put_sym(ws_byte());
			put_word(1, 4);
			case ($urandom_range(0, 2))
				0: put_sym(CH_COLON);
				1: begin
					put_sym(ws_byte());
					put_sym(CH_COLON);
				end
				default: begin
					put_sym(CH_COLON);
					put_sym(ws_byte());
				end
			endcase
			put_word(1, 4);
			if (p == n_prop - 1 && $urandom_range(0, 1)) begin
				put_sym(ws_byte());
			end else begin
				if ($urandom_range(0, 1))
					put_sym(ws_byte());
				put_sym(CH_SEMI);
			end
		end
		if ($urandom_range(0, 1))
			put_sym(ws_byte());
		put_sym(CH_RBRACE);
		if ($urandom_range(0, 2) == 0)
			put_sym(CH_LF);
	endfunction

	// walk the parse back to idle from wherever noise left it
	function automatic void close_rule();
		while (shaper.st != ST_IDLE) begin
			case (shaper.st)
				ST_TAG, ST_ID, ST_CLASS: put(CH_COMMA);
				ST_COMB:                 put(shaper.comb_held ? CH_SPACE : CH_COMMA);
				ST_NAME, ST_DELIM:       put(CH_COLON);
				ST_VALUE:                put(CH_SEMI);
				default:                 put(CH_RBRACE);
			endcase
		end
	endfunction

	// ---------------- driving ----------------

	task automatic send_byte(bit [7:0] b);
		int gap;
		gap = draw_gap(tx_steady);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		byte_in <= b;
		do
			@(posedge clk);
		while (full);
		sb.note_byte(b);
	endtask

	task automatic send_text();
		while (text_q.size() > 0)
			send_byte(text_q.pop_front());
	endtask

	task automatic wait_drained();
		while (sb.pending_events.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_first_line(bit v);
		push <= 1'b0;
		wait_drained();
		cfg_valid <= 1'b1;
		first_line_number <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.load_first_line(v);
	endtask

	// result side: random pops, one long hold-off to fill the block up
	initial begin
		int gap;
		wait (arst_n);
		forever begin
			gap = draw_gap(rx_steady);
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			if (popped == HOLD_AT) begin
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			pop <= 1'b1;
			do
				@(posedge clk);
			while (empty);
			sb.check_event(event_kind, char_value, error_code, line_number, last_of_run);
			popped++;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("watchdog: no item moved for %0d cycles", QUIET_LIMIT);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: byte extremes, hash after class, hash after combinator, full property block
		write_first_line(1'b0);
		put(8'hFF);
		put_str(".c#d ~ #e,\n");
		put_str("p\t>#q{n:");
		put(8'h00);
		put_str(" ;}");
		send_text();

		noisy = 1'b1;
		write_first_line(1'b1);
		while (text_q.size() < PHASE_BYTES)
			gen_rule();
		close_rule();
		send_text();

		write_first_line(1'b0);
		while (text_q.size() < PHASE_BYTES)
			gen_rule();
		close_rule();
		noisy = 1'b0;

		// end the run on one malformed sequence, then bytes the dead parser must ignore
		tail_used = fault_tail_t'($urandom_range(0, 6));
		case (tail_used)
			FT_ATTR: begin
				put_str("a.b");
				put_raw(CH_LBRACK);
			end
			FT_HASH: begin
				put_str("#x");
				put_raw(CH_HASH);
			end
			FT_COMB_TWICE: begin
				put_str("a >");
				put_raw(CH_GT);
			end
			FT_COMB_BRACE: begin
				put_str("a >");
				put_raw(CH_LBRACE);
			end
			FT_AFTER_NAME: begin
				put_str("a{n ");
				put_raw("x");
			end
			FT_AFTER_VALUE: begin
				put_str("a{n:v ");
				put_raw("w");
			end
			default: begin
				put_str("a ~");
				put_raw(CH_LBRACK);
			end
		endcase
		put_raw(CH_LF);
		repeat (5) put_raw(8'($urandom_range(0, 255)));
		send_text();

		push <= 1'b0;
		wait_drained();
		$display("covered %0d bytes under both first-line settings, %0d events checked",
			sb.bytes_noted, sb.events_checked);
		$display("event kinds seen %011b, closing fault %s", sb.kinds_seen[10:0],
			tail_used.name());
		if (sb.mismatches == 0 && sb.pending_events.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d mismatches, %0d events never seen", sb.mismatches,
				sb.pending_events.size());
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/csstok_pkg.sv
rtl/core/csstok_front.sv
rtl/core/csstok_queue.sv
rtl/core/csstok_back.sv
rtl/core/css_selector_rule_tokenizer_core.sv
tb/tb_css_selector_rule_tokenizer_core.sv
